// ----- hdl/w2rgb_pkg.sv -----
// constants, widths and the gamma threshold table for the wavelength to rgb block
// no dependencies; imported by hdl/wavelength_to_rgb.sv
package w2rgb_pkg;

   // gamma table resolution (fraction bits of the table index)
   localparam int unsigned GAMMA_INDEX_BITS = 12;
   localparam int unsigned IDX_W            = GAMMA_INDEX_BITS + 1;

   // output levels 0..255, found by one search step per level bit
   localparam int unsigned LEVEL_BITS = 8;
   localparam int unsigned LEVELS     = 1 << LEVEL_BITS;

   localparam int unsigned NCH       = 3;
   localparam int unsigned NLANE     = 2;
   localparam int unsigned LANE_RAMP = 0;
   localparam int unsigned LANE_EDGE = 1;
   localparam int unsigned CH_RED    = 0;
   localparam int unsigned CH_GREEN  = 1;
   localparam int unsigned CH_BLUE   = 2;

   // q1.16 values and datapath widths
   localparam int unsigned W_W         = 10;
   localparam int unsigned NUM_W       = 10;
   localparam int unsigned Q16_W       = 17;
   localparam int unsigned X_W         = 27;
   localparam int unsigned DEN_W       = 11;
   localparam int unsigned RECIP_SHIFT = 27;
   localparam int unsigned RECIP_W     = 22;
   localparam int unsigned QD_W        = Q16_W + DEN_W;
   localparam int unsigned PROD_W      = 2 * Q16_W - 1;
   localparam int unsigned ROUND_SHIFT = 32 - GAMMA_INDEX_BITS;

   localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(65536);

   // breakpoints in nm
   localparam logic [W_W-1:0] W_LOW      = W_W'(380);
   localparam logic [W_W-1:0] W_BLUE     = W_W'(440);
   localparam logic [W_W-1:0] W_CYAN     = W_W'(490);
   localparam logic [W_W-1:0] W_GREEN    = W_W'(510);
   localparam logic [W_W-1:0] W_YELLOW   = W_W'(580);
   localparam logic [W_W-1:0] W_RED      = W_W'(645);
   localparam logic [W_W-1:0] W_HIGH     = W_W'(780);
   localparam logic [W_W-1:0] W_EDGE_LO  = W_W'(420);
   localparam logic [W_W-1:0] W_EDGE_HI  = W_W'(700);

   // edge fall-off numerators
   localparam logic [NUM_W-1:0] F_LOW_BASE  = NUM_W'(120);
   localparam logic [NUM_W-1:0] F_HIGH_BASE = NUM_W'(240);
   localparam logic [NUM_W-1:0] F_SLOPE     = NUM_W'(7);

   // doubled denominators for round(65536*num/den) = (131072*num + den) / (2*den)
   localparam logic [DEN_W-1:0] D_RED_FALL   = DEN_W'(120);
   localparam logic [DEN_W-1:0] D_GREEN_RISE = DEN_W'(100);
   localparam logic [DEN_W-1:0] D_BLUE_FALL  = DEN_W'(40);
   localparam logic [DEN_W-1:0] D_RED_RISE   = DEN_W'(140);
   localparam logic [DEN_W-1:0] D_GREEN_FALL = DEN_W'(130);
   localparam logic [DEN_W-1:0] D_EDGE_LO    = DEN_W'(800);
   localparam logic [DEN_W-1:0] D_EDGE_HI    = DEN_W'(1600);

   // floor reciprocals, quotient estimate is low by at most one
   localparam logic [RECIP_W-1:0] M_RED_FALL   = RECIP_W'((64'd1 << RECIP_SHIFT) / D_RED_FALL);
   localparam logic [RECIP_W-1:0] M_GREEN_RISE = RECIP_W'((64'd1 << RECIP_SHIFT) / D_GREEN_RISE);
   localparam logic [RECIP_W-1:0] M_BLUE_FALL  = RECIP_W'((64'd1 << RECIP_SHIFT) / D_BLUE_FALL);
   localparam logic [RECIP_W-1:0] M_RED_RISE   = RECIP_W'((64'd1 << RECIP_SHIFT) / D_RED_RISE);
   localparam logic [RECIP_W-1:0] M_GREEN_FALL = RECIP_W'((64'd1 << RECIP_SHIFT) / D_GREEN_FALL);
   localparam logic [RECIP_W-1:0] M_EDGE_LO    = RECIP_W'((64'd1 << RECIP_SHIFT) / D_EDGE_LO);
   localparam logic [RECIP_W-1:0] M_EDGE_HI    = RECIP_W'((64'd1 << RECIP_SHIFT) / D_EDGE_HI);

   // cycles from an accepted item to its result strobe
   localparam int unsigned PIPE_LATENCY = 8 + LEVEL_BITS;

   // level k is reached once p^4 * 510^5 >= (2k-1)^5 * 2^(4*bits)
   localparam logic [127:0] K510_POW5 = 128'd34502525100000;

   typedef logic [LEVELS-1:0][IDX_W-1:0] thr_table_type;

   function automatic logic [127:0] gamma_lhs(logic [127:0] p);
      return p * p * p * p * K510_POW5;
   endfunction

   // smallest table index that reaches each level, swept upward once
   function automatic thr_table_type build_thresholds();
      thr_table_type t;
      logic [127:0]  odd;
      logic [127:0]  rhs;
      logic [127:0]  p;
      t = '0;
      p = '0;
      for (int k = 1; k < LEVELS; k++) begin
         odd = 128'(2 * k - 1);
         rhs = (odd * odd * odd * odd * odd) << (4 * GAMMA_INDEX_BITS);
         while (gamma_lhs(p) < rhs) p = p + 128'd1;
         t[k] = p[IDX_W-1:0];
      end
      return t;
   endfunction

   localparam thr_table_type GAMMA_THR = build_thresholds();

endpackage

// ----- hdl/wavelength_to_rgb.sv -----
// wavelength to 8-bit rgb: piecewise ramps, edge fall-off, gamma 0.8 by threshold search
// depends on hdl/w2rgb_pkg.sv
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  -------------------------------
//  request   req_wavelength_nm                      start high, busy low at the edge
//  result    rsp_red, rsp_green, rsp_blue           rsp_strobe high for one cycle
//
// one item per cycle; each item passes through these registers in order:
// 7 stages of input register, decode, reciprocal divide, back-multiply, correction,
// product and rounding, 8 stages of binary search over the 255 gamma thresholds
// (one level bit each), then the output register.
// reset is synchronous; busy is high only during reset, and reset drops items in flight.
// the receiver cannot stall, so the pipeline never holds.
module wavelength_to_rgb
   import w2rgb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [W_W-1:0]   req_wavelength_nm,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue
);

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_ONE,
      SEL_RAMP
   } chan_sel_type;

   typedef struct packed {
      logic                         white;
      chan_sel_type [NCH-1:0]       sel;
      logic                         f_one;
   } ctl_type;

   // stage registers
   logic                 v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [W_W-1:0]       w_ff;
   ctl_type              ctl1_ff, ctl1_in, ctl2_ff, ctl3_ff;
   logic [X_W-1:0]       x1_ff [NLANE];
   logic [X_W-1:0]       x1_in [NLANE];
   logic [RECIP_W-1:0]   m1_ff [NLANE];
   logic [RECIP_W-1:0]   m1_in [NLANE];
   logic [DEN_W-1:0]     d1_ff [NLANE];
   logic [DEN_W-1:0]     d1_in [NLANE];
   logic [X_W-1:0]       x2_ff [NLANE];
   logic [DEN_W-1:0]     d2_ff [NLANE];
   logic [Q16_W-1:0]     qe2_ff [NLANE];
   logic [Q16_W-1:0]     qe2_in [NLANE];
   logic [X_W-1:0]       x3_ff [NLANE];
   logic [DEN_W-1:0]     d3_ff [NLANE];
   logic [Q16_W-1:0]     qe3_ff [NLANE];
   logic [QD_W-1:0]      qd3_ff [NLANE];
   logic [QD_W-1:0]      qd3_in [NLANE];
   logic                 white4_ff, white5_ff, white6_ff;
   logic [Q16_W-1:0]     c4_ff [NCH];
   logic [Q16_W-1:0]     c4_in [NCH];
   logic [Q16_W-1:0]     f4_ff, f4_in;
   logic [PROD_W-1:0]    prod5_ff [NCH];
   logic [IDX_W-1:0]     idx6_ff [NCH];
   logic [IDX_W-1:0]     idx6_in [NCH];

   // search stages
   logic [LEVEL_BITS-1:0]  vs_ff;
   logic [LEVEL_BITS-1:0]  whites_ff;
   logic [IDX_W-1:0]       idxs_ff [LEVEL_BITS-1][NCH];
   logic [IDX_W-1:0]       idxs_in [LEVEL_BITS-1][NCH];
   logic [LEVEL_BITS-1:0]  ns_ff [LEVEL_BITS][NCH];
   logic [LEVEL_BITS-1:0]  ns_in [LEVEL_BITS][NCH];

   logic                 rsp_strobe_ff;
   logic [7:0]           rsp_ff [NCH];
   logic [7:0]           rsp_in [NCH];

   logic                 accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // decode: segment, ramp numerator and edge factor numerator
   always_comb begin
      logic [NUM_W-1:0]    ramp_num;
      logic [NUM_W-1:0]    edge_num;
      logic [DEN_W-1:0]    ramp_d;
      logic [DEN_W-1:0]    edge_d;
      logic [RECIP_W-1:0]  ramp_m;
      logic [RECIP_W-1:0]  edge_m;
      ramp_num = '0;
      edge_num = '0;
      ramp_d   = D_RED_FALL;
      ramp_m   = M_RED_FALL;
      edge_d   = D_EDGE_LO;
      edge_m   = M_EDGE_LO;
      ctl1_in.white = (w_ff < W_LOW) || (w_ff > W_HIGH);
      ctl1_in.sel   = '{default: SEL_ZERO};
      ctl1_in.f_one = 1'b0;
      priority if (w_ff < W_BLUE) begin
         ctl1_in.sel[CH_RED]  = SEL_RAMP;
         ctl1_in.sel[CH_BLUE] = SEL_ONE;
         ramp_num = W_BLUE - w_ff;
      end else if (w_ff < W_CYAN) begin
         ctl1_in.sel[CH_GREEN] = SEL_RAMP;
         ctl1_in.sel[CH_BLUE]  = SEL_ONE;
         ramp_num = w_ff - W_BLUE;
         ramp_d   = D_GREEN_RISE;
         ramp_m   = M_GREEN_RISE;
      end else if (w_ff < W_GREEN) begin
         ctl1_in.sel[CH_GREEN] = SEL_ONE;
         ctl1_in.sel[CH_BLUE]  = SEL_RAMP;
         ramp_num = W_GREEN - w_ff;
         ramp_d   = D_BLUE_FALL;
         ramp_m   = M_BLUE_FALL;
      end else if (w_ff < W_YELLOW) begin
         ctl1_in.sel[CH_RED]   = SEL_RAMP;
         ctl1_in.sel[CH_GREEN] = SEL_ONE;
         ramp_num = w_ff - W_GREEN;
         ramp_d   = D_RED_RISE;
         ramp_m   = M_RED_RISE;
      end else if (w_ff < W_RED) begin
         ctl1_in.sel[CH_RED]   = SEL_ONE;
         ctl1_in.sel[CH_GREEN] = SEL_RAMP;
         ramp_num = W_RED - w_ff;
         ramp_d   = D_GREEN_FALL;
         ramp_m   = M_GREEN_FALL;
      end else begin
         ctl1_in.sel[CH_RED] = SEL_ONE;
      end
      priority if (w_ff < W_EDGE_LO) begin
         edge_num = F_LOW_BASE + F_SLOPE * (w_ff - W_LOW);
      end else if (w_ff <= W_EDGE_HI) begin
         ctl1_in.f_one = 1'b1;
      end else begin
         edge_num = F_HIGH_BASE + F_SLOPE * (W_HIGH - w_ff);
         edge_d   = D_EDGE_HI;
         edge_m   = M_EDGE_HI;
      end
      // dividend 131072*num + den, divisor 2*den
      x1_in[LANE_RAMP] = {ramp_num, 17'd0} + X_W'(ramp_d >> 1);
      x1_in[LANE_EDGE] = {edge_num, 17'd0} + X_W'(edge_d >> 1);
      m1_in[LANE_RAMP] = ramp_m;
      m1_in[LANE_EDGE] = edge_m;
      d1_in[LANE_RAMP] = ramp_d;
      d1_in[LANE_EDGE] = edge_d;
   end

   // reciprocal estimate and back-multiply, both lanes
   always_comb begin
      logic [X_W+RECIP_W-1:0] est;
      for (int l = 0; l < NLANE; l++) begin
         est       = (X_W + RECIP_W)'(x1_ff[l]) * (X_W + RECIP_W)'(m1_ff[l]);
         qe2_in[l] = Q16_W'(est >> RECIP_SHIFT);
         qd3_in[l] = QD_W'(qe2_ff[l]) * QD_W'(d2_ff[l]);
      end
   end

   // correction by one, then channel and edge values
   always_comb begin
      logic [X_W-1:0]   rem;
      logic [Q16_W-1:0] q [NLANE];
      for (int l = 0; l < NLANE; l++) begin
         rem  = x3_ff[l] - X_W'(qd3_ff[l]);
         q[l] = qe3_ff[l] + Q16_W'(rem >= X_W'(d3_ff[l]));
      end
      for (int ch = 0; ch < NCH; ch++) begin
         unique case (ctl3_ff.sel[ch])
            SEL_ZERO: c4_in[ch] = '0;
            SEL_ONE:  c4_in[ch] = Q16_ONE;
            SEL_RAMP: c4_in[ch] = q[LANE_RAMP];
            default:  c4_in[ch] = '0;
         endcase
      end
      f4_in = ctl3_ff.f_one ? Q16_ONE : q[LANE_EDGE];
   end

   // round the q1.32 product to a gamma table index
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         idx6_in[ch] = IDX_W'((prod5_ff[ch] + (PROD_W'(1) << (ROUND_SHIFT - 1)))
                              >> ROUND_SHIFT);
      end
   end

   // binary search: one level bit per stage, largest level whose threshold is reached
   always_comb begin
      logic [LEVEL_BITS-1:0] n_src;
      logic [LEVEL_BITS-1:0] cand;
      logic [IDX_W-1:0]      idx_src;
      for (int j = 0; j < LEVEL_BITS; j++) begin
         for (int ch = 0; ch < NCH; ch++) begin
            if (j == 0) begin
               n_src   = '0;
               idx_src = idx6_ff[ch];
            end else begin
               n_src   = ns_ff[j-1][ch];
               idx_src = idxs_ff[j-1][ch];
            end
            cand = n_src | (LEVEL_BITS'(1) << (LEVEL_BITS - 1 - j));
            ns_in[j][ch] = (GAMMA_THR[cand] <= idx_src) ? cand : n_src;
            if (j < LEVEL_BITS - 1) idxs_in[j][ch] = idx_src;
         end
      end
   end

   // out of band items give white
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         rsp_in[ch] = whites_ff[LEVEL_BITS-1] ? 8'hFF : ns_ff[LEVEL_BITS-1][ch];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         v6_ff         <= 1'b0;
         vs_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v0_ff         <= accept;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= v4_ff;
         v6_ff         <= v5_ff;
         vs_ff         <= {vs_ff[LEVEL_BITS-2:0], v6_ff};
         rsp_strobe_ff <= vs_ff[LEVEL_BITS-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      w_ff    <= req_wavelength_nm;
      ctl1_ff <= ctl1_in;
      ctl2_ff <= ctl1_ff;
      ctl3_ff <= ctl2_ff;
      for (int l = 0; l < NLANE; l++) begin
         x1_ff[l]  <= x1_in[l];
         m1_ff[l]  <= m1_in[l];
         d1_ff[l]  <= d1_in[l];
         x2_ff[l]  <= x1_ff[l];
         d2_ff[l]  <= d1_ff[l];
         qe2_ff[l] <= qe2_in[l];
         x3_ff[l]  <= x2_ff[l];
         d3_ff[l]  <= d2_ff[l];
         qe3_ff[l] <= qe2_ff[l];
         qd3_ff[l] <= qd3_in[l];
      end
      white4_ff <= ctl3_ff.white;
      white5_ff <= white4_ff;
      white6_ff <= white5_ff;
      f4_ff     <= f4_in;
      for (int ch = 0; ch < NCH; ch++) begin
         c4_ff[ch]    <= c4_in[ch];
         prod5_ff[ch] <= PROD_W'(c4_ff[ch]) * PROD_W'(f4_ff);
         idx6_ff[ch]  <= idx6_in[ch];
         rsp_ff[ch]   <= rsp_in[ch];
      end
      whites_ff <= {whites_ff[LEVEL_BITS-2:0], white6_ff};
      for (int j = 0; j < LEVEL_BITS; j++) begin
         for (int ch = 0; ch < NCH; ch++) begin
            ns_ff[j][ch] <= ns_in[j][ch];
         end
      end
      for (int j = 0; j < LEVEL_BITS - 1; j++) begin
         for (int ch = 0; ch < NCH; ch++) begin
            idxs_ff[j][ch] <= idxs_in[j][ch];
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_red    = rsp_ff[CH_RED];
   assign rsp_green  = rsp_ff[CH_GREEN];
   assign rsp_blue   = rsp_ff[CH_BLUE];

   // every accepted item comes out after the fixed latency
   a_latency_out : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY rsp_strobe)
      else $error("accepted item produced no result");

   // no result without an item accepted the latency earlier
   a_no_invented : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LATENCY))
      else $error("result strobe without accepted item");

   // out of band gives white
   a_white : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (($past(req_wavelength_nm, PIPE_LATENCY) < W_LOW) ||
                      ($past(req_wavelength_nm, PIPE_LATENCY) > W_HIGH)))
      |-> (rsp_red == 8'hFF && rsp_green == 8'hFF && rsp_blue == 8'hFF))
      else $error("out of band item not white");

   // plain red band gives full red and no blue
   a_red_band : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_wavelength_nm, PIPE_LATENCY) >= W_RED) &&
                     ($past(req_wavelength_nm, PIPE_LATENCY) <= W_EDGE_HI))
      |-> (rsp_red == 8'hFF && rsp_blue == 8'h00))
      else $error("red band item not full red");

endmodule
